// ===== rtl/core/assert_macros.svh =====
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication checked every clock, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/dprs_pkg.sv =====
// ----------------------------------------------------------------------------
// dprs_pkg
// shared types and constants of the disc percentile rank select core
// ----------------------------------------------------------------------------
package dprs_pkg;

  localparam int unsigned ChW = 16;
  localparam int unsigned LumaW = 32;
  localparam logic [15:0] WRed = 16'd14581;
  localparam logic [15:0] WGreen = 16'd46983;
  localparam logic [15:0] WBlue = 16'd3972;
  localparam logic [16:0] Q16One = 17'd65536;

  localparam logic [0:0] RegRadius = 1'b0;
  localparam logic [0:0] RegPercentile = 1'b1;

  // classified sample handed from front to back
  typedef struct packed {
    logic            keep;
    logic            last;
    logic [LumaW-1:0] luma;
    logic [ChW-1:0]  red;
    logic [ChW-1:0]  green;
    logic [ChW-1:0]  blue;
    logic [ChW-1:0]  alpha;
  } sample_t;

endpackage

// ===== rtl/core/dprs_ram.sv =====
// ----------------------------------------------------------------------------
// dprs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dprs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/dprs_front.sv =====
// ----------------------------------------------------------------------------
// dprs_front
// disc test and luma computation, two registered stages
// ----------------------------------------------------------------------------
module dprs_front #(
  parameter int unsigned MaxRadius = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           radius_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [4:0]    dx_i,
  input  logic signed [4:0]    dy_i,
  input  logic                 in_image_i,
  input  logic [15:0]          red_i,
  input  logic [15:0]          green_i,
  input  logic [15:0]          blue_i,
  input  logic [15:0]          alpha_i,
  input  logic                 last_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output dprs_pkg::sample_t    sample_o
);
  import dprs_pkg::*;

  logic       s1_valid_q, s2_valid_q;
  logic       s1_adv, s2_adv;
  logic       s1_keep_q, s1_last_q;
  logic [15:0] s1_r_q, s1_g_q, s1_b_q, s1_a_q;
  logic [31:0] pr_q, pg_q, pb_q;
  sample_t    s2_q;
  logic [3:0] rad;
  logic [9:0] d2, r2;

  assign rad = ({28'd0, radius_i} > MaxRadius) ? 4'(MaxRadius) : radius_i;
  assign d2 = 10'(dx_i * dx_i) + 10'(dy_i * dy_i);
  assign r2 = 10'(rad * rad);

  assign s2_adv = !s2_valid_q || ready_i;
  assign s1_adv = !s1_valid_q || s2_adv;
  assign ready_o = s1_adv;
  assign valid_o = s2_valid_q;
  assign sample_o = s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= valid_i;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && valid_i) begin
      s1_keep_q <= in_image_i && (d2 < r2);
      s1_last_q <= last_i;
      s1_r_q <= red_i;
      s1_g_q <= green_i;
      s1_b_q <= blue_i;
      s1_a_q <= alpha_i;
      pr_q <= red_i * WRed;
      pg_q <= green_i * WGreen;
      pb_q <= blue_i * WBlue;
    end
    if (s2_adv && s1_valid_q) begin
      s2_q.keep <= s1_keep_q;
      s2_q.last <= s1_last_q;
      s2_q.luma <= pr_q + pg_q + pb_q;
      s2_q.red <= s1_r_q;
      s2_q.green <= s1_g_q;
      s2_q.blue <= s1_b_q;
      s2_q.alpha <= s1_a_q;
    end
  end

endmodule

// ===== rtl/core/dprs_fifo.sv =====
// ----------------------------------------------------------------------------
// dprs_fifo
// short queue of classified samples between front and back
// ----------------------------------------------------------------------------
module dprs_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  dprs_pkg::sample_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output dprs_pkg::sample_t data_o
);
  import dprs_pkg::*;

  localparam int unsigned AW = $clog2(Depth);

  sample_t      mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;

  assign ready_o = cnt_q != (AW+1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o = mem_q[rp_q];
  assign push = valid_i && ready_o;
  assign pop = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end

endmodule

// ===== rtl/core/dprs_back.sv =====
// ----------------------------------------------------------------------------
// dprs_back
// sorted insertion into ram store and percentile readout
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dprs_back #(
  parameter int unsigned MaxKept = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [16:0]       percentile_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  dprs_pkg::sample_t sample_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [15:0]       out_red_o,
  output logic [15:0]       out_green_o,
  output logic [15:0]       out_blue_o,
  output logic [15:0]       out_alpha_o,
  output logic              empty_window_o
);
  import dprs_pkg::*;

  localparam int unsigned AW = $clog2(MaxKept);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned RW = 96;

  // search reads pos upward; shift reads k-1 and writes k downward
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSrch = 3'd1;
  localparam logic [2:0] StShft = 3'd2;
  localparam logic [2:0] StIns  = 3'd3;
  localparam logic [2:0] StRank = 3'd4;
  localparam logic [2:0] StRd   = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, pos_q, pos_d, k_q, k_d;
  sample_t       cur_q;
  logic          cur_ld;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic          ovalid_q, ovalid_d;
  logic [63:0]   ocol_q, ocol_d;
  logic          oempty_q, oempty_d;
  logic [16:0]   pct;
  logic [CW+16:0] prod_q;
  logic [CW-1:0] rank;
  logic          rd_pend_q, rd_pend_d;

  dprs_ram #(.Width(RW), .Depth(MaxKept)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign pct = (percentile_i > Q16One) ? Q16One : percentile_i;
  assign rank = (CW'((prod_q + (CW+17)'(16'hffff)) >> 16) > cnt_q - 1'b1)
      ? cnt_q - 1'b1 : CW'((prod_q + (CW+17)'(16'hffff)) >> 16);

  assign ready_o = (st_q == StIdle) && !(ovalid_q && !ready_i);
  assign valid_o = ovalid_q;
  assign out_red_o = ocol_q[15:0];
  assign out_green_o = ocol_q[31:16];
  assign out_blue_o = ocol_q[47:32];
  assign out_alpha_o = ocol_q[63:48];
  assign empty_window_o = oempty_q;

  always_comb begin
    st_d = st_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    k_d = k_q;
    cur_ld = 1'b0;
    we = 1'b0;
    waddr = k_q[AW-1:0];
    wdata = rdata;
    raddr = pos_q[AW-1:0];
    ovalid_d = ovalid_q && !ready_i;
    ocol_d = ocol_q;
    oempty_d = oempty_q;
    rd_pend_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (valid_i && ready_o) begin
          cur_ld = 1'b1;
          pos_d = '0;
          raddr = '0;
          rd_pend_d = 1'b1;
          if (sample_i.keep && cnt_q != CW'(MaxKept)) st_d = StSrch;
          else if (sample_i.last) st_d = StRank;
        end
      end
      StSrch: begin
        // rdata holds entry pos_q when rd_pend_q
        if (pos_q == cnt_q || (rd_pend_q && rdata[RW-1 -: 32] >= cur_q.luma)) begin
          k_d = cnt_q;
          raddr = AW'(cnt_q - 1'b1);
          rd_pend_d = 1'b1;
          st_d = (cnt_q == pos_q) ? StIns : StShft;
        end else if (!rd_pend_q) begin
          raddr = pos_q[AW-1:0];
          rd_pend_d = 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
          raddr = AW'(pos_q + 1'b1);
          rd_pend_d = 1'b1;
        end
      end
      StShft: begin
        if (rd_pend_q) begin
          we = 1'b1;
          waddr = k_q[AW-1:0];
          wdata = rdata;
          k_d = k_q - 1'b1;
          if (k_q - 1'b1 == pos_q) st_d = StIns;
          else begin
            raddr = AW'(k_q - 2'd2);
            rd_pend_d = 1'b1;
          end
        end
      end
      StIns: begin
        we = 1'b1;
        waddr = pos_q[AW-1:0];
        wdata = {cur_q.luma, cur_q.alpha, cur_q.blue, cur_q.green, cur_q.red};
        cnt_d = cnt_q + 1'b1;
        st_d = cur_q.last ? StRank : StIdle;
      end
      StRank: begin
        st_d = StRd;
      end
      StRd: begin
        raddr = rank[AW-1:0];
        st_d = StOut;
      end
      StOut: begin
        if (!ovalid_q || ready_i) begin
          ovalid_d = 1'b1;
          oempty_d = cnt_q == '0;
          ocol_d = (cnt_q == '0) ? 64'd0 : rdata[63:0];
          cnt_d = '0;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cnt_q <= '0;
      ovalid_q <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      ovalid_q <= ovalid_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    k_q <= k_d;
    ocol_q <= ocol_d;
    oempty_q <= oempty_d;
    prod_q <= (CW+17)'(cnt_q * pct);
    if (cur_ld) cur_q <= sample_i;
  end

  `ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= CW'(MaxKept))
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, ovalid_q && !ready_i, ovalid_q)
  `ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, st_q != StIdle, !ready_o)

endmodule

// ===== rtl/core/disc_percentile_rank_select_core.sv =====
// ----------------------------------------------------------------------------
// disc_percentile_rank_select_core
// disc window percentile rank filter with a luma sorted sample store
// ----------------------------------------------------------------------------
// channel   direction  handshake
// sample    in         valid_i / ready_o
// result    out        valid_o / ready_i
// config    in         apb write, pready always high
//
// a dropped sample is taken in the idle state; a kept one goes through
// upward search, downward shift if needed and insert (search and shift
// on one ram port); a last sample adds the rank, read and output states
// reset clears the count and control; the store needs no clearing
// a two stage front and a four entry queue absorb back end stalls
`include "assert_macros.svh"
module disc_percentile_rank_select_core #(
  parameter int unsigned MaxKept = 256,
  parameter int unsigned MaxRadius = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic signed [4:0] dx_i,
  input  logic signed [4:0] dy_i,
  input  logic              in_image_i,
  input  logic [15:0]       red_i,
  input  logic [15:0]       green_i,
  input  logic [15:0]       blue_i,
  input  logic [15:0]       alpha_i,
  input  logic              last_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [15:0]       out_red_o,
  output logic [15:0]       out_green_o,
  output logic [15:0]       out_blue_o,
  output logic [15:0]       out_alpha_o,
  output logic              empty_window_o
);
  import dprs_pkg::*;

  logic [3:0]  radius_q;
  logic [16:0] percentile_q;
  logic        f_valid, f_ready, b_valid, b_ready;
  sample_t     f_data, b_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPercentile) ? {15'd0, percentile_q}
                                              : {28'd0, radius_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 4'd4;
      percentile_q <= 17'd32768;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegRadius) radius_q <= pwdata[3:0];
      else percentile_q <= pwdata[16:0];
    end
  end

  dprs_front #(.MaxRadius(MaxRadius)) u_front (
    .clk_i, .rst_ni, .radius_i(radius_q),
    .valid_i, .ready_o, .dx_i, .dy_i, .in_image_i,
    .red_i, .green_i, .blue_i, .alpha_i, .last_i,
    .valid_o(f_valid), .ready_i(f_ready), .sample_o(f_data)
  );

  dprs_fifo #(.Depth(4)) u_fifo (
    .clk_i, .rst_ni, .valid_i(f_valid), .ready_o(f_ready), .data_i(f_data),
    .valid_o(b_valid), .ready_i(b_ready), .data_o(b_data)
  );

  dprs_back #(.MaxKept(MaxKept)) u_back (
    .clk_i, .rst_ni, .percentile_i(percentile_q),
    .valid_i(b_valid), .ready_o(b_ready), .sample_i(b_data),
    .valid_o, .ready_i, .out_red_o, .out_green_o, .out_blue_o,
    .out_alpha_o, .empty_window_o
  );

  `ASSERT_IMP(a_empty_zero, clk_i, rst_ni, valid_o && empty_window_o,
              out_red_o == 16'd0 && out_alpha_o == 16'd0)

endmodule
